// ===== sv/ucd_pkg.sv =====
// ----------------------------------------------------------------------------
// ucd_pkg
// shared types and constants of the undirected cycle detector
// ----------------------------------------------------------------------------
package ucd_pkg;

   localparam int unsigned MAX_VERTICES_DEF = 256;
   localparam int unsigned MAX_EDGES_DEF    = 1024;
   localparam int unsigned VID_W            = 8;
   localparam int unsigned CNT_W            = 9;
   localparam logic [CNT_W-1:0] COUNT_RESET = 9'd256;

   typedef enum logic [1:0] {
      STATUS_ACYCLIC = 2'd0,
      STATUS_CYCLE   = 2'd1,
      STATUS_OVERFLOW = 2'd2,
      STATUS_RANGE   = 2'd3
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic add;        // store incoming edge
      logic scan_start; // begin range scan of stored entries
      logic walk_start; // begin search over roots
      logic clear;      // empty store and flags
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic       add_busy; // reverse entry of the last edge being stored
      logic       done;
      status_type status;
   } stat_type;

endpackage

// ===== sv/ucd_datapath.sv =====
// ----------------------------------------------------------------------------
// ucd_datapath
// edge store, visited marks, walk stack and the search sequencer
// ----------------------------------------------------------------------------
module ucd_datapath #(
   parameter int unsigned MAX_VERTICES = ucd_pkg::MAX_VERTICES_DEF,
   parameter int unsigned MAX_EDGES    = ucd_pkg::MAX_EDGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ucd_pkg::cmd_type              cmd,
   input  logic [ucd_pkg::VID_W-1:0]     end_a,
   input  logic [ucd_pkg::VID_W-1:0]     end_b,
   input  logic [ucd_pkg::CNT_W-1:0]     vertex_count,
   output ucd_pkg::stat_type             stat
);
   localparam int unsigned ENT   = 2 * MAX_EDGES;
   localparam int unsigned EA_W  = $clog2(ENT);
   localparam int unsigned ET_W  = $clog2(MAX_EDGES + 1);
   localparam int unsigned EC_W  = $clog2(ENT + 1);
   localparam int unsigned VX_W  = $clog2(MAX_VERTICES);
   localparam int unsigned VC_W  = $clog2(MAX_VERTICES + 1);
   localparam int unsigned W_W   = (VC_W > ucd_pkg::CNT_W) ? VC_W : ucd_pkg::CNT_W;

   typedef enum logic [2:0] {
      D_IDLE, D_SCAN, D_ROOT, D_CLR, D_FRAME, D_READ, D_STEP
   } dstate_type;

   // edge store: src and dst packed into one word
   logic [2*ucd_pkg::VID_W-1:0] store_mem [ENT];
   logic [2*ucd_pkg::VID_W-1:0] rd_data_ff;
   logic [EA_W-1:0]             rd_addr;
   logic                        wr_en;
   logic [EA_W-1:0]             wr_addr;
   logic [2*ucd_pkg::VID_W-1:0] wr_data;

   // walk stack: vertex, parent (msb set when none), cursor
   logic [VX_W-1:0] stk_v   [MAX_VERTICES];
   logic [VX_W:0]   stk_p   [MAX_VERTICES];
   logic [EC_W-1:0] stk_c   [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] visited_ff;

   dstate_type      state_ff;
   logic [ET_W-1:0] total_ff;
   logic [1:0]      flags_ff;
   logic            add_phase_ff;
   logic [EC_W-1:0] k_ff;
   logic [VC_W-1:0] top_ff;
   logic [VX_W-1:0] cur_v_ff;
   logic [VX_W:0]   cur_p_ff;
   logic [VC_W-1:0] root_ff;
   logic            done_ff;
   ucd_pkg::status_type status_ff;
   logic [ucd_pkg::VID_W-1:0] a_ff, b_ff;

   logic [W_W-1:0]  live;
   logic [EC_W-1:0] entries;
   logic [ucd_pkg::VID_W-1:0] rs, rd;
   logic [VX_W-1:0] rd_v;
   logic [VC_W-1:0] top_m1;

   assign live = ({{(W_W-ucd_pkg::CNT_W){1'b0}}, vertex_count} > W_W'(MAX_VERTICES)) ?
                 W_W'(MAX_VERTICES) : {{(W_W-ucd_pkg::CNT_W){1'b0}}, vertex_count};
   assign entries = EC_W'({total_ff, 1'b0});
   assign rs = rd_data_ff[2*ucd_pkg::VID_W-1:ucd_pkg::VID_W];
   assign rd = rd_data_ff[ucd_pkg::VID_W-1:0];
   assign rd_v = VX_W'(rd);
   assign top_m1 = top_ff - VC_W'(1);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = {a_ff, b_ff};
      if (add_phase_ff) begin
         wr_en   = 1'b1;
         wr_addr = EA_W'({total_ff, 1'b1});
         wr_data = {b_ff, a_ff};
      end else if (cmd.add) begin
         wr_en   = (W_W'(end_a) < live) && (W_W'(end_b) < live)
                   && (total_ff < ET_W'(MAX_EDGES));
         wr_addr = EA_W'({total_ff, 1'b0});
         wr_data = {end_a, end_b};
      end
   end

   assign rd_addr = k_ff[EA_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= D_IDLE;
         total_ff     <= '0;
         flags_ff     <= '0;
         add_phase_ff <= 1'b0;
         done_ff      <= 1'b0;
         visited_ff   <= '0;
         top_ff       <= '0;
      end else begin
         done_ff      <= 1'b0;
         add_phase_ff <= 1'b0;
         if (add_phase_ff) begin
            total_ff <= total_ff + ET_W'(1);
         end
         if (cmd.add) begin
            a_ff <= end_a;
            b_ff <= end_b;
            if ((W_W'(end_a) >= live) || (W_W'(end_b) >= live)) begin
               flags_ff[1] <= 1'b1;
            end else if (total_ff >= ET_W'(MAX_EDGES)) begin
               flags_ff[0] <= 1'b1;
            end else begin
               add_phase_ff <= 1'b1;
            end
         end
         if (cmd.clear) begin
            total_ff   <= '0;
            flags_ff   <= '0;
            visited_ff <= '0;
            top_ff     <= '0;
         end
         unique case (state_ff)
            D_IDLE: begin
               if (cmd.scan_start) begin
                  k_ff     <= '0;
                  state_ff <= D_SCAN;
               end
            end
            D_SCAN: begin
               // one read in flight, check the word read last cycle
               if (k_ff != '0 && (W_W'(rs) >= live || W_W'(rd) >= live)) begin
                  flags_ff[1] <= 1'b1;
               end
               if (k_ff >= entries) begin
                  state_ff <= D_ROOT;
                  root_ff  <= '0;
                  visited_ff <= '0;
               end else begin
                  k_ff <= k_ff + EC_W'(1);
               end
            end
            D_ROOT: begin
               if (flags_ff[1]) begin
                  status_ff <= ucd_pkg::STATUS_RANGE;
                  done_ff   <= 1'b1;
                  state_ff  <= D_IDLE;
               end else if (flags_ff[0]) begin
                  status_ff <= ucd_pkg::STATUS_OVERFLOW;
                  done_ff   <= 1'b1;
                  state_ff  <= D_IDLE;
               end else if (W_W'(root_ff) >= live) begin
                  status_ff <= ucd_pkg::STATUS_ACYCLIC;
                  done_ff   <= 1'b1;
                  state_ff  <= D_IDLE;
               end else if (visited_ff[root_ff[VX_W-1:0]]) begin
                  root_ff <= root_ff + VC_W'(1);
               end else begin
                  visited_ff[root_ff[VX_W-1:0]] <= 1'b1;
                  stk_v[0] <= root_ff[VX_W-1:0];
                  stk_p[0] <= {1'b1, {VX_W{1'b0}}};
                  stk_c[0] <= '0;
                  top_ff   <= VC_W'(1);
                  state_ff <= D_FRAME;
               end
            end
            D_FRAME: begin
               if (top_ff == '0) begin
                  root_ff  <= root_ff + VC_W'(1);
                  state_ff <= D_ROOT;
               end else begin
                  cur_v_ff <= stk_v[top_m1[VX_W-1:0]];
                  cur_p_ff <= stk_p[top_m1[VX_W-1:0]];
                  k_ff     <= stk_c[top_m1[VX_W-1:0]];
                  state_ff <= D_READ;
               end
            end
            D_READ: begin
               if (k_ff >= entries) begin
                  top_ff   <= top_ff - VC_W'(1);
                  state_ff <= D_FRAME;
               end else begin
                  state_ff <= D_STEP;
               end
            end
            D_STEP: begin
               if (VX_W'(rs) != cur_v_ff || (VX_W < ucd_pkg::VID_W &&
                   (W_W'(rs) >= W_W'(MAX_VERTICES)))) begin
                  k_ff     <= k_ff + EC_W'(1);
                  state_ff <= D_READ;
               end else begin
                  stk_c[top_m1[VX_W-1:0]] <= k_ff + EC_W'(1);
                  state_ff <= D_FRAME;
                  if (!visited_ff[rd_v]) begin
                     if (top_ff < VC_W'(MAX_VERTICES)) begin
                        visited_ff[rd_v]        <= 1'b1;
                        stk_v[top_ff[VX_W-1:0]] <= rd_v;
                        stk_p[top_ff[VX_W-1:0]] <= {1'b0, cur_v_ff};
                        stk_c[top_ff[VX_W-1:0]] <= '0;
                        top_ff <= top_ff + VC_W'(1);
                     end
                  end else if ({1'b0, rd_v} != cur_p_ff) begin
                     status_ff <= ucd_pkg::STATUS_CYCLE;
                     done_ff   <= 1'b1;
                     state_ff  <= D_IDLE;
                  end
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign stat.add_busy = add_phase_ff;
   assign stat.done     = done_ff;
   assign stat.status   = status_ff;

endmodule

// ===== sv/ucd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ucd_ctrl
// handshake and sequencing of add and evaluate items
// ----------------------------------------------------------------------------
module ucd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_mode,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output ucd_pkg::cmd_type           cmd,
   input  ucd_pkg::stat_type          stat,
   output logic                       idle
);
   typedef enum logic [1:0] {C_IDLE, C_GAP, C_BUSY, C_OUT} cstate_type;

   cstate_type state_ff;
   logic       rsp_valid_ff;
   logic [1:0] status_ff;
   logic       accept;

   assign req_stall = (state_ff != C_IDLE) || stat.add_busy;
   assign accept    = req_valid && !req_stall;
   assign idle      = (state_ff == C_IDLE) && !stat.add_busy;

   always_comb begin
      cmd            = '0;
      cmd.add        = accept && !req_mode;
      cmd.scan_start = (state_ff == C_GAP);
      cmd.clear      = stat.done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            C_IDLE: begin
               if (accept && req_mode) begin
                  state_ff <= C_GAP;
               end
            end
            C_GAP: state_ff <= C_BUSY;
            C_BUSY: begin
               if (stat.done) begin
                  status_ff    <= stat.status;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= C_OUT;
               end
            end
            C_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= C_IDLE;
               end
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;

   a_resp_only_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == C_OUT)) else $error("rsp without state");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (state_ff == C_BUSY)) else $error("done outside search");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == C_BUSY) |-> !accept) else $error("accept while busy");
endmodule

// ===== sv/undirected_cycle_detect_top.sv =====
// ----------------------------------------------------------------------------
// undirected_cycle_detect_top
// cycle detection over a loaded undirected graph
// ----------------------------------------------------------------------------
// req channel: mode 0 adds edge (end_a, end_b), mode 1 evaluates the graph.
// an add gives no result; after an add that is stored, req stalls for one cycle
// while the reverse entry is stored, so no new item is taken until then.
// an evaluate blocks req (stall) until its status item is taken on rsp.
// evaluate: a range scan of all stored entries comes first; a flagged graph
// answers once the scan ends. a search then goes through root checks, stack
// frame visits and stored entry reads, all on the single edge store read port.
// csr channel writes vertex_count; ready is high while no item is in work.
// reset (synchronous) empties the store, clears flags, sets vertex_count 256.
// while rsp is stalled the status holds and no new item is accepted.
// ----------------------------------------------------------------------------
module undirected_cycle_detect_top #(
   parameter int unsigned MAX_VERTICES = ucd_pkg::MAX_VERTICES_DEF,
   parameter int unsigned MAX_EDGES    = ucd_pkg::MAX_EDGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_end_a,
   input  logic [7:0]  req_end_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_vertex_count
);
   ucd_pkg::cmd_type  cmd;
   ucd_pkg::stat_type stat;
   logic              idle;
   logic [8:0]        count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= ucd_pkg::COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_vertex_count;
      end
   end
   assign csr_ready = idle;

   ucd_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .cmd(cmd), .stat(stat), .idle(idle)
   );

   ucd_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .end_a(req_end_a), .end_b(req_end_b),
      .vertex_count(count_ff), .stat(stat)
   );
endmodule

// ===== sim/tb_undirected_cycle_detect_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_undirected_cycle_detect_top
// self-checking bench for the undirected cycle detector: edges and evaluates
// go in on req, each evaluate status is checked against a local dfs model,
// with vertex_count changes, store overflow, range errors and random stalls
// ----------------------------------------------------------------------------
module tb_undirected_cycle_detect_top;

   localparam int unsigned EDGE_CAP  = ucd_pkg::MAX_EDGES_DEF;
   localparam int unsigned VERT_CAP  = ucd_pkg::MAX_VERTICES_DEF;
   localparam int unsigned IDLE_LIMIT = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_mode = 1'b0;
   logic [7:0] req_end_a = '0;
   logic [7:0] req_end_b = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [8:0] csr_vertex_count = '0;

   undirected_cycle_detect_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_end_a(req_end_a), .req_end_b(req_end_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_vertex_count(csr_vertex_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // graph model
   logic [7:0]   edge_src[2*EDGE_CAP];
   logic [7:0]   edge_dst[2*EDGE_CAP];
   int unsigned  edges_held = 0;
   bit           flag_overflow = 0;
   bit           flag_range = 0;
   logic [8:0]   vertex_count_reg = ucd_pkg::COUNT_RESET;
   bit           seen[VERT_CAP];
   int           frame_vertex[VERT_CAP];
   int           frame_parent[VERT_CAP];
   int unsigned  frame_cursor[VERT_CAP];
   ucd_pkg::status_type status_queue[$];

   int unsigned  send_idle_pct = 0;
   int unsigned  recv_stall_pct = 0;
   bit           failed = 0;
   int unsigned  quiet_cycles = 0;

   function automatic int unsigned live_vertices();
      return (vertex_count_reg > VERT_CAP) ? VERT_CAP : int'(vertex_count_reg);
   endfunction

   function automatic bit walk_finds_cycle(int root);
      int unsigned entries;
      int unsigned depth;
      int unsigned k;
      int nb;
      entries = 2 * edges_held;
      seen[root] = 1;
      frame_vertex[0] = root;
      frame_parent[0] = -1;
      frame_cursor[0] = 0;
      depth = 1;
      while (depth > 0) begin
         k = frame_cursor[depth-1];
         while (k < entries && int'(edge_src[k]) != frame_vertex[depth-1]) k++;
         if (k >= entries) begin
            depth--;
         end else begin
            frame_cursor[depth-1] = k + 1;
            nb = edge_dst[k];
            if (!seen[nb]) begin
               if (depth < VERT_CAP) begin
                  seen[nb] = 1;
                  frame_vertex[depth] = nb;
                  frame_parent[depth] = frame_vertex[depth-1];
                  frame_cursor[depth] = 0;
                  depth++;
               end
            end else if (nb != frame_parent[depth-1]) begin
               return 1;
            end
         end
      end
      return 0;
   endfunction

   function automatic ucd_pkg::status_type graph_status();
      int unsigned n;
      n = live_vertices();
      for (int unsigned i = 0; i < 2 * edges_held; i++)
         if (edge_src[i] >= n || edge_dst[i] >= n) flag_range = 1;
      if (flag_range) return ucd_pkg::STATUS_RANGE;
      if (flag_overflow) return ucd_pkg::STATUS_OVERFLOW;
      foreach (seen[i]) seen[i] = 0;
      for (int unsigned i = 0; i < n; i++)
         if (!seen[i] && walk_finds_cycle(i)) return ucd_pkg::STATUS_CYCLE;
      return ucd_pkg::STATUS_ACYCLIC;
   endfunction

   // updates the model for one accepted item, returns the expected status
   function automatic ucd_pkg::status_type absorb_item(bit mode, logic [7:0] a,
                                                       logic [7:0] b);
      int unsigned n;
      ucd_pkg::status_type s;
      s = ucd_pkg::STATUS_ACYCLIC;
      n = live_vertices();
      if (!mode) begin
         if (a >= n || b >= n) begin
            flag_range = 1;
         end else if (edges_held >= EDGE_CAP) begin
            flag_overflow = 1;
         end else begin
            edge_src[2*edges_held] = a;
            edge_dst[2*edges_held] = b;
            edge_src[2*edges_held+1] = b;
            edge_dst[2*edges_held+1] = a;
            edges_held++;
         end
      end else begin
         s = graph_status();
         edges_held = 0;
         flag_overflow = 0;
         flag_range = 0;
      end
      return s;
   endfunction

   // drive one item, return at its acceptance edge
   task automatic send_item(bit mode, logic [7:0] a, logic [7:0] b,
                            bit known = 0,
                            ucd_pkg::status_type want = ucd_pkg::STATUS_ACYCLIC);
      ucd_pkg::status_type s;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_mode  <= 1'($urandom_range(1));
         req_end_a <= 8'($urandom);
         req_end_b <= 8'($urandom);
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_end_a <= a;
      req_end_b <= b;
      do @(posedge clock); while (req_stall);
      s = absorb_item(mode, a, b);
      if (mode) status_queue.insert(status_queue.size(), known ? want : s);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_count(logic [8:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_vertex_count <= value;
      do @(posedge clock); while (!csr_ready);
      vertex_count_reg = value;
      csr_valid <= 1'b0;
   endtask

   task automatic random_graph(int unsigned max_edges);
      int unsigned k;
      int unsigned n;
      logic [7:0] a, b;
      n = live_vertices();
      k = $urandom_range(max_edges);
      repeat (k) begin
         if (n == 0 || $urandom_range(99) < 6) begin
            a = 8'($urandom);
            b = 8'($urandom);
         end else begin
            a = 8'($urandom_range(n - 1));
            b = ($urandom_range(99) < 8) ? a : 8'($urandom_range(n - 1));
         end
         send_item(1'b0, a, b);
      end
      send_item(1'b1, 8'($urandom), 8'($urandom));
   endtask

   // response checking
   always @(posedge clock) begin
      ucd_pkg::status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_queue.size() == 0) begin
            $error("status: no result expected, got %0d", rsp_status);
            failed = 1;
         end else begin
            want = status_queue.pop_front();
            if (rsp_status !== want) begin
               $error("status: expected %0d, actual %0d", want, rsp_status);
               failed = 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb_undirected_cycle_detect_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   typedef struct packed {
      bit         mode;
      logic [7:0] a;
      logic [7:0] b;
      bit         known;
      ucd_pkg::status_type want;
   } row_type;

   localparam int ROWS = 15;
   localparam row_type DIRECTED[ROWS] = '{
      '{1'b1, 8'd0,   8'd0,   1'b1, ucd_pkg::STATUS_ACYCLIC},
      '{1'b0, 8'd0,   8'd0,   1'b0, ucd_pkg::STATUS_ACYCLIC},
      '{1'b1, 8'd255, 8'd255, 1'b1, ucd_pkg::STATUS_CYCLE},
      '{1'b0, 8'd0,   8'd1,   1'b0, ucd_pkg::STATUS_ACYCLIC},
      '{1'b0, 8'd1,   8'd0,   1'b0, ucd_pkg::STATUS_ACYCLIC},
      '{1'b1, 8'd0,   8'd0,   1'b0, ucd_pkg::STATUS_ACYCLIC},
      '{1'b0, 8'd255, 8'd254, 1'b0, ucd_pkg::STATUS_ACYCLIC},
      '{1'b0, 8'd254, 8'd253, 1'b0, ucd_pkg::STATUS_ACYCLIC},
      '{1'b0, 8'd253, 8'd255, 1'b0, ucd_pkg::STATUS_ACYCLIC},
      '{1'b1, 8'd170, 8'd85,  1'b0, ucd_pkg::STATUS_ACYCLIC},
      '{1'b0, 8'd0,   8'd255, 1'b0, ucd_pkg::STATUS_ACYCLIC},
      '{1'b0, 8'd85,  8'd170, 1'b0, ucd_pkg::STATUS_ACYCLIC},
      '{1'b0, 8'd255, 8'd255, 1'b0, ucd_pkg::STATUS_ACYCLIC},
      '{1'b1, 8'd0,   8'd0,   1'b0, ucd_pkg::STATUS_ACYCLIC},
      '{1'b1, 8'd0,   8'd0,   1'b1, ucd_pkg::STATUS_ACYCLIC}
   };

   initial begin
      int unsigned counts[8] = '{1, 2, 5, 16, 256, 0, 40, 511};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < ROWS; i++)
         send_item(DIRECTED[i].mode, DIRECTED[i].a, DIRECTED[i].b,
                   DIRECTED[i].known, DIRECTED[i].want);

      // empty graph and any edge with no vertices
      write_count(9'd0);
      send_item(1'b1, 8'd0, 8'd0, 1'b1, ucd_pkg::STATUS_ACYCLIC);
      send_item(1'b0, 8'd0, 8'd0);
      send_item(1'b1, 8'd0, 8'd0, 1'b1, ucd_pkg::STATUS_RANGE);
      // count lowered after loading
      write_count(9'd8);
      send_item(1'b0, 8'd7, 8'd6);
      send_item(1'b0, 8'd1, 8'd2);
      write_count(9'd4);
      send_item(1'b1, 8'd0, 8'd0, 1'b1, ucd_pkg::STATUS_RANGE);
      // saturating count
      write_count(9'd511);
      send_item(1'b0, 8'd3, 8'd3);
      send_item(1'b1, 8'd0, 8'd0, 1'b1, ucd_pkg::STATUS_CYCLE);
      // full store, then full store plus range error
      write_count(9'd256);
      repeat (EDGE_CAP + 1) send_item(1'b0, 8'($urandom), 8'($urandom));
      send_item(1'b1, 8'd0, 8'd0, 1'b1, ucd_pkg::STATUS_OVERFLOW);
      write_count(9'd200);
      repeat (EDGE_CAP + 1)
         send_item(1'b0, 8'($urandom_range(199)), 8'($urandom_range(199)));
      send_item(1'b0, 8'd250, 8'd0);
      send_item(1'b1, 8'd0, 8'd0, 1'b1, ucd_pkg::STATUS_RANGE);

      for (int p = 0; p < 8; p++) begin
         write_count(9'(counts[p]));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         for (int g = 0; g < 8; g++) begin
            random_graph((g == 7) ? 30 : 10);
            if (g == 3 && p == 2) drain();
         end
      end

      drain();
      recv_stall_pct = 0;
      repeat (100) @(posedge clock);
      if (!failed && status_queue.size() == 0) begin
         $display("tb_undirected_cycle_detect_top: PASS");
      end else begin
         $display("tb_undirected_cycle_detect_top: FAIL");
      end
      $finish;
   end

endmodule
